// ===== src/a2b_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package a2b_pkg;

	// Frame size limit; byte positions saturate here.
	localparam int MAX_FRAME_BYTES = 1048576;
	localparam int OFF_W = $clog2(MAX_FRAME_BYTES);
	localparam int POS_W = OFF_W + 1;

	// Fixed field widths of the result item.
	localparam int START_OFFSET_W = 20;
	localparam int OUT_LENGTH_W = 21;

	// Field phase codes: four length bytes, then header, then payload.
	localparam logic [2:0] PH_LEN0 = 3'd0;
	localparam logic [2:0] PH_LEN1 = 3'd1;
	localparam logic [2:0] PH_LEN2 = 3'd2;
	localparam logic [2:0] PH_LEN3 = 3'd3;
	localparam logic [2:0] PH_HEADER = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
	localparam logic [7:0] NAL_TYPE_SPS = 8'h07;
	localparam logic [7:0] NAL_TYPE_IDR = 8'h05;
	localparam logic [7:0] NAL_TYPE_SLICE = 8'h01;

	localparam logic [7:0] START_CODE_ZERO = 8'h00;
	localparam logic [7:0] START_CODE_LAST = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} a2b_in_t;

	typedef struct packed {
		logic [7:0]                  out_byte;
		logic                        frame_end;
		logic                        key_frame;
		logic [START_OFFSET_W-1:0]   start_offset;
		logic [OUT_LENGTH_W-1:0]     out_length;
		logic                        malformed;
	} a2b_out_t;

endpackage

`default_nettype wire

// ===== src/a2b_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a2b_in_stage import a2b_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  a2b_in_t      in_data,
	input  wire logic    advance,
	output logic         valid_s1,
	output a2b_in_t      data_s1
);

	// The stage can refill in the same cycle that its item moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/a2b_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a2b_parser import a2b_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  a2b_in_t   item,
	output a2b_out_t  result
);

	logic [2:0]       phase_q, phase_d;
	logic [23:0]      accum_q, accum_d;
	logic [31:0]      left_q, left_d;
	logic [POS_W-1:0] byte_pos_q, byte_pos_d;
	logic [OFF_W-1:0] nal_start_q, nal_start_d;
	logic [OFF_W-1:0] chosen_q, chosen_d;
	logic             key_q, key_d;
	logic             slice_q, slice_d;

	logic [OFF_W-1:0] pos;
	logic [7:0]       nal_type;
	logic [31:0]      len_word;
	logic [31:0]      left_dec;
	logic [7:0]       ob;
	logic             bad;
	logic [POS_W-1:0] chosen_ext;
	logic [POS_W-1:0] frame_len;

	always_comb begin
		pos = (byte_pos_q > POS_W'(MAX_FRAME_BYTES - 1)) ? OFF_W'(MAX_FRAME_BYTES - 1)
			: byte_pos_q[OFF_W-1:0];
		nal_type = item.data_byte & NAL_TYPE_MASK;
		len_word = {accum_q, item.data_byte};
		left_dec = left_q - 32'd1;

		phase_d = phase_q;
		accum_d = accum_q;
		left_d = left_q;
		nal_start_d = nal_start_q;
		chosen_d = chosen_q;
		key_d = key_q;
		slice_d = slice_q;
		ob = item.data_byte;
		bad = 1'b0;

		priority if (phase_q < PH_HEADER) begin
			if (phase_q == PH_LEN0) begin
				nal_start_d = pos;
				accum_d = {16'd0, item.data_byte};
			end else begin
				accum_d = {accum_q[15:0], item.data_byte};
			end
			if (phase_q == PH_LEN3) begin
				ob = START_CODE_LAST;
				left_d = len_word;
				// A zero-length NAL has no header; the next byte is a length byte.
				phase_d = (len_word == 32'd0) ? PH_LEN0 : PH_HEADER;
			end else begin
				ob = START_CODE_ZERO;
				bad = item.last_byte;
				phase_d = phase_q + 3'd1;
			end
		end else if (phase_q == PH_HEADER) begin
			if ((nal_type == NAL_TYPE_SPS || nal_type == NAL_TYPE_IDR) && !key_q) begin
				key_d = 1'b1;
				chosen_d = nal_start_q;
			end
			// Checked second so that a slice in the same byte would win.
			if (nal_type == NAL_TYPE_SLICE && !slice_q) begin
				slice_d = 1'b1;
				chosen_d = nal_start_q;
			end
			left_d = left_dec;
			phase_d = (left_dec == 32'd0) ? PH_LEN0 : PH_PAYLOAD;
		end else begin
			left_d = (left_q != 32'd0) ? left_dec : left_q;
			phase_d = (left_d == 32'd0) ? PH_LEN0 : PH_PAYLOAD;
		end

		byte_pos_d = (byte_pos_q < POS_W'(MAX_FRAME_BYTES)) ? byte_pos_q + POS_W'(1)
			: byte_pos_q;

		chosen_ext = {1'b0, chosen_d};
		frame_len = (byte_pos_d >= chosen_ext) ? byte_pos_d - chosen_ext : '0;

		result.out_byte = ob;
		result.frame_end = item.last_byte;
		result.key_frame = item.last_byte && key_d;
		result.start_offset = item.last_byte ? START_OFFSET_W'(chosen_d) : '0;
		result.out_length = item.last_byte ? OUT_LENGTH_W'(frame_len) : '0;
		result.malformed = item.last_byte && bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN0;
			accum_q <= '0;
			left_q <= '0;
			byte_pos_q <= '0;
			nal_start_q <= '0;
			chosen_q <= '0;
			key_q <= 1'b0;
			slice_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_LEN0;
				accum_q <= '0;
				left_q <= '0;
				byte_pos_q <= '0;
				nal_start_q <= '0;
				chosen_q <= '0;
				key_q <= 1'b0;
				slice_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				left_q <= left_d;
				byte_pos_q <= byte_pos_d;
				nal_start_q <= nal_start_d;
				chosen_q <= chosen_d;
				key_q <= key_d;
				slice_q <= slice_d;
			end
		end
	end

	a_frame_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.last_byte |=> phase_q == PH_LEN0 && byte_pos_q == '0 && !key_q)
		else $error("per-frame state not cleared after last byte");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_PAYLOAD)
		else $error("field phase out of range");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER || phase_q == PH_PAYLOAD) |-> left_q != 32'd0)
		else $error("payload phase with nothing left");

	a_key_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.last_byte && key_q |=> key_q)
		else $error("key flag dropped inside a frame");

endmodule

`default_nettype wire

// ===== src/a2b_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module a2b_out_stage import a2b_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  a2b_out_t  result,
	output logic      free,
	output logic      out_valid,
	input  wire logic out_ready,
	output a2b_out_t  out_data
);

	// The register takes a new result when empty or when its result leaves now.
	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= result;
		end
	end

endmodule

`default_nettype wire

// ===== src/avcc_to_annexb_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                        | Transfer when
// ---------+--------------------------------+----------------------------
// input    | in_valid, in_ready, in_data    | in_valid && in_ready
// output   | out_valid, out_ready, out_data | out_valid && out_ready
//
// Each byte is held in the input register and is then parsed in a single
// combinational pass into the result register. One byte per cycle is
// sustained while out_ready is high; the parser state update is one short step.
// A stalled output holds the result register, then the input register; the
// input side keeps taking bytes while either register has room.
// Reset (arst_n low) empties both registers and clears all per-frame state.

module avcc_to_annexb_converter_core import a2b_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  a2b_in_t   in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output a2b_out_t  out_data
);

	logic     valid_s1;
	a2b_in_t  data_s1;
	logic     out_free;
	logic     advance;
	a2b_out_t result;

	// The byte in the input register is parsed, and the parser state moves on,
	// exactly in the cycle that its result enters the output register.
	assign advance = valid_s1 && out_free;

	a2b_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// Replaces length bytes with start code bytes and tracks the NAL types,
	// the chosen start offset and the frame length.
	a2b_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (data_s1),
		.result (result)
	);

	a2b_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
